[hdl/linear_probe_hash_table_top_defines.svh]
// Assertion helpers for the hash table block.
`ifndef LINEAR_PROBE_HASH_TABLE_TOP_DEFINES_SVH
`define LINEAR_PROBE_HASH_TABLE_TOP_DEFINES_SVH

// Same-cycle implication, checked on clock, off during reset.
`define LPHT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on clock, off during reset.
`define LPHT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/lpht_pkg.sv]
package lpht_pkg;

   localparam int TABLE_SIZE_DEF = 16;

   localparam int MODE_W     = 2;
   localparam int KEY_W      = 31;
   localparam int STATUS_W   = 2;
   localparam int SLOT_W     = 4;
   localparam int TAG_W      = 2;
   // compare-subtract steps that bring the folded key below TABLE_SIZE
   localparam int HASH_STEPS = $clog2(KEY_W + 1);
   localparam int HCNT_W     = $clog2(HASH_STEPS);

   // stream words, padded to whole bytes
   localparam int REQ_DATA_W = ((MODE_W + KEY_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((STATUS_W + SLOT_W + 7) / 8) * 8;

   localparam logic [MODE_W-1:0] OP_INSERT = 2'd0;
   localparam logic [MODE_W-1:0] OP_SEARCH = 2'd1;
   localparam logic [MODE_W-1:0] OP_DELETE = 2'd2;

   localparam logic [TAG_W-1:0] TAG_EMPTY   = 2'd0;
   localparam logic [TAG_W-1:0] TAG_USED    = 2'd1;
   localparam logic [TAG_W-1:0] TAG_DELETED = 2'd2;

   localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

   typedef struct packed {
      logic                load;         // capture request word, fold key
      logic                hash_step;    // one compare-subtract step
      logic                ptr_home;     // pointer to home slot
      logic                ptr_adv;      // pointer to next slot, wrapping
      logic                wr_en;        // write slot at pointer
      logic [TAG_W-1:0]    wr_tag;
      logic                res_load;     // capture pending result
      logic [STATUS_W-1:0] res_status;
      logic                res_use_slot;
      logic                out_load;     // pending result to output register
   } lpht_cmd_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [TAG_W-1:0]  tag;
      logic              key_hit;
   } lpht_sts_type;

endpackage

[hdl/lpht_ctrl.sv]
module lpht_ctrl #(
   parameter int TABLE_SIZE = lpht_pkg::TABLE_SIZE_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  lpht_pkg::lpht_sts_type sts,
   output lpht_pkg::lpht_cmd_type cmd
);
   import lpht_pkg::*;

   localparam int IDX_W   = $clog2(TABLE_SIZE);
   localparam bit IS_POW2 = (TABLE_SIZE & (TABLE_SIZE - 1)) == 0;
   localparam logic [IDX_W-1:0]  LAST_SLOT = IDX_W'(TABLE_SIZE - 1);
   localparam logic [HCNT_W-1:0] LAST_BIT  = HCNT_W'(HASH_STEPS - 1);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_HASH  = 3'd2;
   localparam logic [2:0] S_START = 3'd3;
   localparam logic [2:0] S_PROBE = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;

   logic [2:0]        state_ff, state_in;
   logic [IDX_W-1:0]  n_ff, n_in;
   logic [HCNT_W-1:0] hcnt_ff, hcnt_in;
   logic              out_valid_ff, out_valid_in;
   logic              last_probe;

   assign last_probe = (n_ff == LAST_SLOT);
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = out_valid_ff;

   always_comb begin
      state_in = state_ff;
      n_in     = n_ff;
      hcnt_in  = hcnt_ff;
      cmd      = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_tag  = TAG_EMPTY;
            cmd.ptr_adv = 1'b1;
            n_in        = n_ff + 1'b1;
            if (last_probe) begin
               n_in     = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               hcnt_in  = '0;
               state_in = IS_POW2 ? S_START : S_HASH;
            end
         end
         S_HASH: begin
            cmd.hash_step = 1'b1;
            hcnt_in       = hcnt_ff + 1'b1;
            if (hcnt_ff == LAST_BIT) begin
               state_in = S_START;
            end
         end
         S_START: begin
            n_in = '0;
            if (sts.mode inside {OP_INSERT, OP_SEARCH, OP_DELETE}) begin
               cmd.ptr_home = 1'b1;
               state_in     = S_PROBE;
            end else begin
               // unknown op: nothing probed
               cmd.res_load   = 1'b1;
               cmd.res_status = ST_NOT_FOUND;
               state_in       = S_DONE;
            end
         end
         S_PROBE: begin
            if (sts.mode == OP_INSERT) begin
               if (sts.tag != TAG_USED) begin
                  cmd.wr_en        = 1'b1;
                  cmd.wr_tag       = TAG_USED;
                  cmd.res_load     = 1'b1;
                  cmd.res_status   = ST_INSERTED;
                  cmd.res_use_slot = 1'b1;
                  state_in         = S_DONE;
               end else if (last_probe) begin
                  cmd.res_load   = 1'b1;
                  cmd.res_status = ST_FULL;
                  state_in       = S_DONE;
               end else begin
                  cmd.ptr_adv = 1'b1;
                  n_in        = n_ff + 1'b1;
               end
            end else begin
               if (sts.tag == TAG_EMPTY) begin
                  cmd.res_load   = 1'b1;
                  cmd.res_status = ST_NOT_FOUND;
                  state_in       = S_DONE;
               end else if (sts.tag == TAG_USED && sts.key_hit) begin
                  cmd.res_load     = 1'b1;
                  cmd.res_status   = ST_FOUND;
                  cmd.res_use_slot = 1'b1;
                  cmd.wr_en        = (sts.mode == OP_DELETE);
                  cmd.wr_tag       = TAG_DELETED;
                  state_in         = S_DONE;
               end else if (last_probe) begin
                  cmd.res_load   = 1'b1;
                  cmd.res_status = ST_NOT_FOUND;
                  state_in       = S_DONE;
               end else begin
                  cmd.ptr_adv = 1'b1;
                  n_in        = n_ff + 1'b1;
               end
            end
         end
         S_DONE: begin
            if (!out_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
            n_in     = '0;
         end
      endcase
   end

   assign out_valid_in = cmd.out_load | (out_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         n_ff         <= '0;
         hcnt_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         n_ff         <= n_in;
         hcnt_ff      <= hcnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

[hdl/lpht_dp.sv]
module lpht_dp #(
   parameter int TABLE_SIZE = lpht_pkg::TABLE_SIZE_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [lpht_pkg::MODE_W-1:0]   req_mode,
   input  logic [lpht_pkg::KEY_W-1:0]    req_key,
   input  lpht_pkg::lpht_cmd_type        cmd,
   output lpht_pkg::lpht_sts_type        sts,
   output logic [lpht_pkg::STATUS_W-1:0] rsp_status,
   output logic [lpht_pkg::SLOT_W-1:0]   rsp_slot_index
);
   import lpht_pkg::*;

   localparam int IDX_W   = $clog2(TABLE_SIZE);
   localparam int ENTRY_W = TAG_W + KEY_W;
   localparam int FOLD_W  = IDX_W + HASH_STEPS;
   localparam int LEAVES  = 1 << HASH_STEPS;
   localparam bit IS_POW2 = (TABLE_SIZE & (TABLE_SIZE - 1)) == 0;
   localparam logic [IDX_W-1:0]  LAST_SLOT = IDX_W'(TABLE_SIZE - 1);
   localparam logic [FOLD_W-1:0] TOP_MULT  = FOLD_W'(TABLE_SIZE << (HASH_STEPS - 1));

   // 2^b mod TABLE_SIZE, evaluated at elaboration
   function automatic int pow2_mod(input int b);
      int w;
      w = 1;
      for (int j = 0; j < b; j++) begin
         w = (w * 2) % TABLE_SIZE;
      end
      return w;
   endfunction

   // slot table: {tag, key}
   logic [ENTRY_W-1:0] mem [TABLE_SIZE];
   logic [ENTRY_W-1:0] rd_ff;

   logic [MODE_W-1:0]   mode_ff;
   logic [KEY_W-1:0]    key_ff;
   logic [FOLD_W-1:0]   tree [1:2*LEAVES-1];
   logic [FOLD_W-1:0]   acc_ff, mult_ff, acc_sub;
   logic [IDX_W-1:0]    home;
   logic [IDX_W-1:0]    ptr_ff, ptr_in, ptr_next;
   logic [IDX_W+SLOT_W-1:0] slot_ext;
   logic [STATUS_W-1:0] res_status_ff, out_status_ff;
   logic [SLOT_W-1:0]   res_slot_ff, out_slot_ff;

   // key mod TABLE_SIZE, first pass: sum of 2^i mod TABLE_SIZE over set key bits
   for (genvar g = 0; g < LEAVES; g++) begin : g_leaf
      if (g < KEY_W) begin : g_bit
         localparam logic [FOLD_W-1:0] WT = FOLD_W'(pow2_mod(g));
         assign tree[LEAVES + g] = req_key[g] ? WT : '0;
      end else begin : g_pad
         assign tree[LEAVES + g] = '0;
      end
   end
   for (genvar k = 1; k < LEAVES; k++) begin : g_node
      assign tree[k] = tree[2*k] + tree[2*k+1];
   end

   // second pass: subtract 16, 8, 4, 2, 1 times TABLE_SIZE where it fits
   assign acc_sub = (acc_ff >= mult_ff) ? acc_ff - mult_ff : acc_ff;
   assign home    = IS_POW2 ? key_ff[IDX_W-1:0] : acc_ff[IDX_W-1:0];

   assign ptr_next = (ptr_ff == LAST_SLOT) ? '0 : ptr_ff + 1'b1;
   assign ptr_in   = cmd.ptr_home ? home : (cmd.ptr_adv ? ptr_next : ptr_ff);
   assign slot_ext = {{SLOT_W{1'b0}}, ptr_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff <= '0;
      end else begin
         ptr_ff <= ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= req_mode;
         key_ff  <= req_key;
         acc_ff  <= tree[1];
         mult_ff <= TOP_MULT;
      end else if (cmd.hash_step) begin
         acc_ff  <= acc_sub;
         mult_ff <= mult_ff >> 1;
      end
      if (cmd.res_load) begin
         res_status_ff <= cmd.res_status;
         res_slot_ff   <= cmd.res_use_slot ? slot_ext[SLOT_W-1:0] : '0;
      end
      if (cmd.out_load) begin
         out_status_ff <= res_status_ff;
         out_slot_ff   <= res_slot_ff;
      end
   end

   // read follows the next pointer so rd_ff always reflects ptr_ff
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[ptr_ff] <= {cmd.wr_tag, key_ff};
      end
      rd_ff <= mem[ptr_in];
   end

   assign sts.mode    = mode_ff;
   assign sts.tag     = rd_ff[ENTRY_W-1:KEY_W];
   assign sts.key_hit = (rd_ff[KEY_W-1:0] == key_ff);

   assign rsp_status     = out_status_ff;
   assign rsp_slot_index = out_slot_ff;

endmodule

[hdl/linear_probe_hash_table_top.sv]
// Hash table of 31-bit keys, open addressing with linear probing over TABLE_SIZE slots;
// home slot is key mod TABLE_SIZE. Each request word carries an op (insert, search,
// delete) and a key and returns exactly one response word with a status and a slot.
// Insert takes the first empty or deleted slot and does not check for duplicates;
// delete leaves a tombstone. Walks stop after TABLE_SIZE probes, giving table full or
// not found. One request is in flight at a time: after acceptance the block runs the
// remainder reduction steps when TABLE_SIZE is not a power of two, points at the home
// slot, probes P slots (P is 0 for the unused op code, else 1 to TABLE_SIZE) and hands
// the result to the output register. The slot memory, with one write and one read port,
// is read one slot per cycle while probing. The hand-over waits while the previous
// response word is still unread. After reset a clearing pass marks every slot empty;
// req_tready stays low meanwhile. A finished response sits in an output register, so
// the next request is taken while it waits.
`include "linear_probe_hash_table_top_defines.svh"

module linear_probe_hash_table_top #(
   parameter int TABLE_SIZE = lpht_pkg::TABLE_SIZE_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [lpht_pkg::REQ_DATA_W-1:0] req_tdata,  // mode[1:0], key[32:2], zero pad
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [lpht_pkg::RSP_DATA_W-1:0] rsp_tdata   // status[1:0], slot_index[5:2], pad
);
   import lpht_pkg::*;

   lpht_cmd_type        cmd;
   lpht_sts_type        sts;
   logic [MODE_W-1:0]   req_mode;
   logic [KEY_W-1:0]    req_key;
   logic [STATUS_W-1:0] rsp_status;
   logic [SLOT_W-1:0]   rsp_slot_index;

   // unpack request word
   assign req_mode = req_tdata[MODE_W-1:0];
   assign req_key  = req_tdata[MODE_W+KEY_W-1:MODE_W];

   lpht_ctrl #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   lpht_dp #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_mode       (req_mode),
      .req_key        (req_key),
      .cmd            (cmd),
      .sts            (sts),
      .rsp_status     (rsp_status),
      .rsp_slot_index (rsp_slot_index)
   );

   // pack response word
   assign rsp_tdata = {{(RSP_DATA_W - STATUS_W - SLOT_W){1'b0}}, rsp_slot_index, rsp_status};

   // one word in flight: an accept is never followed by another accept
   `LPHT_ASSERT_NEXT(a_one_in_flight, req_tvalid && req_tready, !req_tready,
                     "second word accepted while busy")
   // a result handed to the output register is shown next cycle
   `LPHT_ASSERT_NEXT(a_out_load_valid, cmd.out_load, rsp_tvalid,
                     "output load without tvalid")
   // a slot is claimed only together with an inserted result
   `LPHT_ASSERT_NOW(a_insert_result, cmd.wr_en && cmd.wr_tag == TAG_USED,
                    cmd.res_load && cmd.res_status == ST_INSERTED,
                    "slot write without insert result")

endmodule

[bench/tb_linear_probe_hash_table_top.sv]
`timescale 1ns / 1ps

module tb_linear_probe_hash_table_top;
   import lpht_pkg::*;

   localparam int TBL          = TABLE_SIZE_DEF;
   localparam int NUM_DIRECTED = 27;
   localparam int NUM_RANDOM   = 1900;
   localparam int POOL         = 20;   // small key pool so homes collide and the table fills
   localparam int MAX_REPORTS  = 10;

   // mode 3 has no op behind it; the block must answer not found, slot 0
   localparam logic [MODE_W-1:0] OP_NOP = 2'd3;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot;
   } rsp_word_type;

   typedef struct packed {
      logic [MODE_W-1:0]   mode;
      logic [KEY_W-1:0]    key;
      logic                typed;   // 1: expected word given in the row
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot;
   } dir_row_type;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // mode[1:0], key[32:2], zero pad
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // status[1:0], slot_index[5:2], pad

   // shadow copy of the table
   logic [KEY_W-1:0] slot_key [TBL];
   logic [TAG_W-1:0] slot_tag [TBL];

   rsp_word_type     pending_q[$];          // responses owed by the block, oldest first
   dir_row_type      dir_rows [NUM_DIRECTED];
   logic [KEY_W-1:0] key_pool [POOL];

   int mismatches    = 0;
   int words_checked = 0;
   int status_seen [4];
   bit quiet         = 1'b0;                 // stretch with no idling on either side

   linear_probe_hash_table_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog, far beyond the slowest legal run of about 2000 words
   initial begin
      #20ms;
      $display("FAILED: results differ");
      $finish;
   end

   // Mostly no gap, some short, a few long.
   function automatic int idle_len();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Apply one op to the shadow table and return the word the block must send.
   function automatic rsp_word_type hash_table_op(input logic [MODE_W-1:0] mode,
                                                   input logic [KEY_W-1:0]  key);
      rsp_word_type r;
      int           pos;
      int           hit;
      int           n;
      bit           done;
      r.status = ST_NOT_FOUND;
      r.slot   = '0;
      hit      = -1;
      done     = 1'b0;
      pos      = int'(key % TBL);
      if (mode == OP_INSERT) begin
         // first empty or tombstone slot, no duplicate check
         for (n = 0; n < TBL && !done; n++) begin
            if (slot_tag[pos] != TAG_USED) begin
               hit  = pos;
               done = 1'b1;
            end else begin
               pos = (pos + 1) % TBL;
            end
         end
         if (hit < 0) begin
            r.status = ST_FULL;
         end else begin
            slot_key[hit] = key;
            slot_tag[hit] = TAG_USED;
            r.status      = ST_INSERTED;
            r.slot        = hit[SLOT_W-1:0];
         end
      end else if (mode == OP_SEARCH || mode == OP_DELETE) begin
         // stop on empty; skip tombstones and other keys
         for (n = 0; n < TBL && !done; n++) begin
            if (slot_tag[pos] == TAG_EMPTY) begin
               done = 1'b1;
            end else if (slot_tag[pos] == TAG_USED && slot_key[pos] == key) begin
               hit  = pos;
               done = 1'b1;
            end else begin
               pos = (pos + 1) % TBL;
            end
         end
         if (hit >= 0) begin
            if (mode == OP_DELETE) slot_tag[hit] = TAG_DELETED;
            r.status = ST_FOUND;
            r.slot   = hit[SLOT_W-1:0];
         end
      end
      return r;
   endfunction

   // Drive one request word after a random gap; on acceptance record what must come back.
   task automatic send_word(input logic [MODE_W-1:0] mode, input logic [KEY_W-1:0] key,
                            input bit typed, input rsp_word_type typed_rsp);
      int           gap;
      rsp_word_type predicted;
      gap = idle_len();
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_W - MODE_W - KEY_W){1'b0}}, key, mode};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = hash_table_op(mode, key);   // shadow must track typed rows too
      pending_q.push_back(typed ? typed_rsp : predicted);
   endtask

   // Hold off the sender until every owed response has come back.
   task automatic drain_all();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_q.size() != 0) @(posedge clock);
   endtask

   // receiver: random back-pressure
   initial begin
      int gap;
      forever begin
         gap = idle_len();
         @(negedge clock);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   // response checker
   always @(posedge clock) begin : rsp_check
      rsp_word_type got;
      rsp_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status = rsp_tdata[1:0];
         got.slot   = rsp_tdata[5:2];
         status_seen[got.status]++;
         if (pending_q.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("[%0t] unexpected response word: status=%0d slot=%0d",
                        $realtime, got.status, got.slot);
         end else begin
            want = pending_q.pop_front();
            words_checked++;
            if (got.status !== want.status || got.slot !== want.slot) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("[%0t] word %0d: expected status=%0d slot=%0d, got status=%0d slot=%0d",
                           $realtime, words_checked, want.status, want.slot,
                           got.status, got.slot);
            end
         end
      end
   end

   initial begin
      int               i;
      int               p;
      int               home;
      int               ins_pct;
      int               r;
      logic [26:0]      hi;
      logic [MODE_W-1:0] mode;
      logic [KEY_W-1:0] key;
      rsp_word_type     none;

      none = '0;
      for (i = 0; i < 4; i++) status_seen[i] = 0;
      for (i = 0; i < TBL; i++) begin
         slot_key[i] = '0;
         slot_tag[i] = TAG_EMPTY;
      end

      // Directed part. Typed rows: empty table, mode 3, extremes, full table.
      dir_rows[0]  = '{OP_SEARCH, 31'd5,          1'b1, ST_NOT_FOUND, 4'd0};   // miss on empty
      dir_rows[1]  = '{OP_DELETE, 31'd5,          1'b1, ST_NOT_FOUND, 4'd0};
      dir_rows[2]  = '{OP_NOP,    31'h7FFF_FFFF,  1'b1, ST_NOT_FOUND, 4'd0};   // no-op mode
      dir_rows[3]  = '{OP_INSERT, 31'd0,          1'b1, ST_INSERTED,  4'd0};   // key zero
      dir_rows[4]  = '{OP_INSERT, 31'h7FFF_FFFF,  1'b1, ST_INSERTED,  4'd15};  // max key
      dir_rows[5]  = '{OP_INSERT, 31'h7FFF_FFEF,  1'b0, ST_INSERTED,  4'd0};   // wraps 15 -> 0 -> 1
      dir_rows[6]  = '{OP_SEARCH, 31'h7FFF_FFEF,  1'b0, ST_INSERTED,  4'd0};
      dir_rows[7]  = '{OP_DELETE, 31'd0,          1'b0, ST_INSERTED,  4'd0};   // tombstone at 0
      dir_rows[8]  = '{OP_SEARCH, 31'h7FFF_FFEF,  1'b0, ST_INSERTED,  4'd0};   // walk past it
      dir_rows[9]  = '{OP_SEARCH, 31'd0,          1'b0, ST_INSERTED,  4'd0};   // tombstone no match
      dir_rows[10] = '{OP_INSERT, 31'h0000_0010,  1'b0, ST_INSERTED,  4'd0};   // reuses tombstone
      // fill homes 2..14
      dir_rows[11] = '{OP_INSERT, 31'h0000_0002,  1'b0, ST_INSERTED,  4'd0};
      dir_rows[12] = '{OP_INSERT, 31'h2AAA_AAA3,  1'b0, ST_INSERTED,  4'd0};
      dir_rows[13] = '{OP_INSERT, 31'h5555_5554,  1'b0, ST_INSERTED,  4'd0};
      dir_rows[14] = '{OP_INSERT, 31'h1234_5675,  1'b0, ST_INSERTED,  4'd0};
      dir_rows[15] = '{OP_INSERT, 31'h7654_3216,  1'b0, ST_INSERTED,  4'd0};
      dir_rows[16] = '{OP_INSERT, 31'h0F0F_0F07,  1'b0, ST_INSERTED,  4'd0};
      dir_rows[17] = '{OP_INSERT, 31'h70F0_F0F8,  1'b0, ST_INSERTED,  4'd0};
      dir_rows[18] = '{OP_INSERT, 31'h3333_3339,  1'b0, ST_INSERTED,  4'd0};
      dir_rows[19] = '{OP_INSERT, 31'h4CCC_CCCA,  1'b0, ST_INSERTED,  4'd0};
      dir_rows[20] = '{OP_INSERT, 31'h0000_100B,  1'b0, ST_INSERTED,  4'd0};
      dir_rows[21] = '{OP_INSERT, 31'h7FFF_FFFC,  1'b0, ST_INSERTED,  4'd0};
      dir_rows[22] = '{OP_INSERT, 31'h1000_000D,  1'b0, ST_INSERTED,  4'd0};
      dir_rows[23] = '{OP_INSERT, 31'h6000_000E,  1'b0, ST_INSERTED,  4'd0};
      dir_rows[24] = '{OP_INSERT, 31'h4000_0003,  1'b1, ST_FULL,      4'd0};   // table full
      dir_rows[25] = '{OP_SEARCH, 31'h4000_0003,  1'b1, ST_NOT_FOUND, 4'd0};   // full-length walk
      dir_rows[26] = '{OP_DELETE, 31'h7FFF_FFEF,  1'b0, ST_INSERTED,  4'd0};   // hit in full table

      // key pool: random upper bits, homes bunched around the wrap point
      for (p = 0; p < POOL; p++) begin
         hi          = 27'($urandom);
         home        = $urandom_range(0, 1) ? (14 + $urandom_range(0, 3)) % TBL
                                            : $urandom_range(0, TBL - 1);
         key_pool[p] = {hi, home[3:0]};
      end

      // reset; the block then runs its clearing pass with req_tready low
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (i = 0; i < NUM_DIRECTED; i++)
         send_word(dir_rows[i].mode, dir_rows[i].key, dir_rows[i].typed,
                   {dir_rows[i].status, dir_rows[i].slot});
      drain_all();

      // Random part: insert-heavy, balanced and delete-heavy stretches so the
      // table swings between empty, clustered and full, with tombstones in between.
      ins_pct = 45;
      for (i = 0; i < NUM_RANDOM; i++) begin
         if (i % 150 == 0) begin
            case ($urandom_range(0, 2))
               0:       ins_pct = 25;
               1:       ins_pct = 45;
               default: ins_pct = 75;
            endcase
            quiet = ($urandom_range(0, 3) == 0);
            // retire one pool key so stale copies linger in the table
            hi = 27'($urandom);
            key_pool[$urandom_range(0, POOL - 1)] = {hi, 4'($urandom_range(0, TBL - 1))};
         end
         if (i % 500 == 499) drain_all();

         if ($urandom_range(0, 99) < 5) key = KEY_W'($urandom);   // mostly misses
         else                          key = key_pool[$urandom_range(0, POOL - 1)];

         r = $urandom_range(0, 99);
         if (r < 3)             mode = OP_NOP;
         else if (r < ins_pct)  mode = OP_INSERT;
         else if ($urandom_range(0, 99) < 60) mode = OP_SEARCH;
         else                   mode = OP_DELETE;

         send_word(mode, key, 1'b0, none);
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);   // catch any stray extra word

      $display("Ran %0d directed and %0d random requests, %0d response words checked.",
               NUM_DIRECTED, NUM_RANDOM, words_checked);
      $display("Outcomes seen: %0d inserted, %0d hit, %0d miss, %0d table full; %0d mismatches.",
               status_seen[ST_INSERTED], status_seen[ST_FOUND], status_seen[ST_NOT_FOUND],
               status_seen[ST_FULL], mismatches);
      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
